>>> src/u8f_pkg.sv
// ----------------------------------------------------------------------------
// u8f_pkg
// Shared types and constants for the UTF-8 validating byte filter.
// ----------------------------------------------------------------------------
package u8f_pkg;

  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [1:0]  CONT_TAG   = 2'b10;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] MIN_LEN2   = 21'h000080;
  localparam logic [20:0] MIN_LEN3   = 21'h000800;
  localparam logic [20:0] MIN_LEN4   = 21'h010000;
  localparam logic [2:0]  HOLD_MAX   = 3'd4;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
  } out_word_t;

  // emit job for one input word: decided sequence, then optional trailing byte
  typedef struct packed {
    logic [3:0][7:0] seq_bytes;
    logic [2:0]      seq_cnt;
    logic            extra_vld;
    logic [7:0]      extra_byte;
  } job_t;

endpackage

>>> src/utf8_validating_byte_filter_top.sv
// ----------------------------------------------------------------------------
// utf8_validating_byte_filter_top
// Path: each result word goes through the job queue, then the output register.
// Throughput: one input word per cycle unless the queue is full; one output
//   word per cycle while out_ready is high; an item yields n words (n from 0 to 5).
// The job queue (QUEUE_DEPTH entries) absorbs bursts; input stalls when full.
// Reset: synchronous active-low rst_n clears sequence state, mode and queue.
// ----------------------------------------------------------------------------
module utf8_validating_byte_filter_top import u8f_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  // front -> queue
  logic q_push, q_full;
  job_t q_job;
  // queue -> back
  logic q_pop, q_empty;
  job_t q_head;

  // Front: classifies each byte as ASCII, continuation or lead, keeps the
  // pending sequence and decides it on a new lead, ASCII byte or line end.
  // Each input word that yields output pushes one job.
  u8f_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // Queue lets the front keep taking bytes while a multi-byte job drains.
  u8f_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: sequence bytes first, then the trailing ASCII byte; end_of_run
  // marks the last word of the job.
  u8f_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/u8f_front.sv
// ----------------------------------------------------------------------------
// u8f_front
// Accepts bytes, tracks the pending sequence and builds emit jobs.
// ----------------------------------------------------------------------------
module u8f_front import u8f_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic seq_ok(input logic [2:0] cnt, input logic [3:0] len,
                                  input logic [20:0] cp, input logic bad);
    logic [20:0] lo;
    logic        ok;
    case (len)
      4'd2:    lo = MIN_LEN2;
      4'd3:    lo = MIN_LEN3;
      default: lo = MIN_LEN4;
    endcase
    ok = !bad && (len inside {[4'd2:4'd4]}) && ({1'b0, cnt} == len);
    ok = ok && (cp >= lo) && (cp <= CP_MAX) && !((cp >= SURR_LO) && (cp <= SURR_HI));
    return ok;
  endfunction

  logic             ansi_r, ansi_nxt;
  logic [3:0][7:0]  held_r, held_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [3:0]       len_r, len_nxt;
  logic [20:0]      cp_r, cp_nxt;
  logic             bad_r, bad_nxt;

  logic [7:0]       b;
  logic             eol, in_fire;
  logic             is_ascii, is_cont;
  logic [3:0][7:0]  held_c;
  logic [2:0]       cnt_c;
  logic [20:0]      cp_c;
  logic             bad_c;
  logic [3:0][7:0]  d_held;
  logic [2:0]       d_cnt;
  logic [20:0]      d_cp;
  logic             d_bad;
  logic             dec_en;
  logic [3:0]       ones;
  logic [7:0]       lead_bits;

  assign b         = in_data.data_byte;
  assign eol       = in_data.end_of_line;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign is_ascii  = ansi_r || !b[7];
  assign is_cont   = !is_ascii && (b[7:6] == CONT_TAG) && (cnt_r != 3'd0);

  assign ones      = lead_ones(b);
  assign lead_bits = b & (8'h7F >> ones);

  // pending sequence with this continuation folded in
  always_comb begin
    held_c = held_r;
    cnt_c  = cnt_r;
    bad_c  = bad_r;
    cp_c   = {cp_r[14:0], b[5:0]};
    if (cnt_r < HOLD_MAX) begin
      held_c[cnt_r[1:0]] = b;
      cnt_c              = cnt_r + 3'd1;
    end else begin
      bad_c = 1'b1;
    end
  end

  // sequence to decide: old one, or the updated one on end of line
  always_comb begin
    if (is_cont) begin
      d_held = held_c;
      d_cnt  = cnt_c;
      d_cp   = cp_c;
      d_bad  = bad_c;
      dec_en = eol;
    end else begin
      d_held = held_r;
      d_cnt  = cnt_r;
      d_cp   = cp_r;
      d_bad  = bad_r;
      dec_en = 1'b1;
    end
  end

  always_comb begin
    q_job.seq_bytes  = d_held;
    q_job.seq_cnt    = (dec_en && seq_ok(d_cnt, len_r, d_cp, d_bad)) ? d_cnt : 3'd0;
    q_job.extra_vld  = is_ascii && (b >= SPACE_CHAR);
    q_job.extra_byte = b;
    q_push           = in_fire && ((q_job.seq_cnt != 3'd0) || q_job.extra_vld);
  end

  always_comb begin
    ansi_nxt = ansi_r;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    cp_nxt   = cp_r;
    bad_nxt  = bad_r;
    if (cfg_valid && cfg_ready) begin
      ansi_nxt = cfg_data;
    end
    if (in_fire) begin
      if (is_ascii || eol) begin
        cnt_nxt = 3'd0;
        len_nxt = 4'd0;
        cp_nxt  = 21'd0;
        bad_nxt = 1'b0;
      end else if (is_cont) begin
        held_nxt = held_c;
        cnt_nxt  = cnt_c;
        cp_nxt   = cp_c;
        bad_nxt  = bad_c;
      end else begin
        held_nxt[0] = b;
        cnt_nxt     = 3'd1;
        len_nxt     = ones;
        cp_nxt      = {13'd0, lead_bits};
        bad_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ansi_r <= 1'b0;
      cnt_r  <= 3'd0;
      len_r  <= 4'd0;
      cp_r   <= 21'd0;
      bad_r  <= 1'b0;
    end else begin
      ansi_r <= ansi_nxt;
      cnt_r  <= cnt_nxt;
      len_r  <= len_nxt;
      cp_r   <= cp_nxt;
      bad_r  <= bad_nxt;
    end
  end

  // held bytes: only entries of the current sequence are ever read
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

>>> src/u8f_queue.sv
// ----------------------------------------------------------------------------
// u8f_queue
// Small register FIFO of emit jobs between front and back.
// ----------------------------------------------------------------------------
module u8f_queue import u8f_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> src/u8f_back.sv
// ----------------------------------------------------------------------------
// u8f_back
// Walks the head job one byte per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module u8f_back import u8f_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic [2:0] pos_r, pos_nxt;
  logic       out_vld_r, out_vld_nxt;
  out_word_t  out_data_r, out_data_nxt;
  logic       load, last;
  logic [2:0] total;
  logic [7:0] sel_byte;

  assign total    = q_head.seq_cnt + {2'b00, q_head.extra_vld};
  assign last     = ((pos_r + 3'd1) == total);
  assign load     = !q_empty && (!out_vld_r || out_ready);
  assign q_pop    = load && last;
  assign sel_byte = (pos_r < q_head.seq_cnt) ? q_head.seq_bytes[pos_r[1:0]]
                                             : q_head.extra_byte;

  always_comb begin
    pos_nxt      = pos_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    if (load) begin
      pos_nxt                 = last ? 3'd0 : pos_r + 3'd1;
      out_vld_nxt             = 1'b1;
      out_data_nxt.out_byte   = sel_byte;
      out_data_nxt.end_of_run = last;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 3'd0;
      out_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 validating byte filter. Words go in with
// random gaps, results come out under random backpressure, and every output
// word is checked against an in-bench filter model fed with each accepted
// input word. Directed cases come first, then long runs of random text.
// ----------------------------------------------------------------------------
module testbench;
  import u8f_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYC  = 8;     // covers the path through queue and output register

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  // calm = 1 turns off idling on both sides
  bit calm = 1'b0;
  int errors = 0;
  int stall_cyc = 0;

  // bench copy of the filter state
  logic [7:0]  seq_buf [4];
  logic [2:0]  seq_cnt   = '0;
  logic [3:0]  lead_ones = '0;
  logic [20:0] seq_cp    = '0;
  logic        seq_long  = 1'b0;
  logic        ansi_on   = 1'b0;

  out_word_t item_words[$];    // words caused by the word being modeled
  out_word_t passed_words[$];  // words still due at the output

  utf8_validating_byte_filter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter model
  // ---------------------------------------------------------------------------

  // whole-sequence verdict: length, overlong, surrogate and range rules
  function automatic bit seq_is_valid();
    logic [20:0] floor_cp;
    if (seq_long || lead_ones < 2 || lead_ones > 4) return 1'b0;
    if ({1'b0, seq_cnt} != lead_ones) return 1'b0;
    case (lead_ones)
      4'd2:    floor_cp = MIN_LEN2;
      4'd3:    floor_cp = MIN_LEN3;
      default: floor_cp = MIN_LEN4;
    endcase
    if (seq_cp < floor_cp || seq_cp > CP_MAX) return 1'b0;
    if (seq_cp >= SURR_LO && seq_cp <= SURR_HI) return 1'b0;
    return 1'b1;
  endfunction

  // decide the pending sequence: emit it whole or drop it whole
  function automatic void close_seq();
    if (seq_cnt != 0) begin
      if (seq_is_valid()) begin
        for (int i = 0; i < seq_cnt; i++)
          item_words.push_back('{out_byte: seq_buf[i], end_of_run: 1'b0});
      end
      seq_cnt   = '0;
      lead_ones = '0;
      seq_cp    = '0;
      seq_long  = 1'b0;
    end
  endfunction

  // any non-ASCII byte that is not a continuation of a pending run leads
  // a new one; a stray continuation leads a run of length one
  function automatic void open_seq(input logic [7:0] b);
    int ones;
    ones = 0;
    while (ones < 8 && b[7-ones]) ones++;
    seq_buf[0] = b;
    seq_cnt    = 3'd1;
    lead_ones  = 4'(ones);
    seq_cp     = 21'(b & (8'h7f >> ones));
    seq_long   = 1'b0;
  endfunction

  function automatic void add_cont(input logic [7:0] b);
    seq_cp = {seq_cp[14:0], b[5:0]};
    if (seq_cnt < HOLD_MAX) begin
      seq_buf[seq_cnt[1:0]] = b;
      seq_cnt++;
    end else begin
      seq_long = 1'b1;  // past four bytes: run is bad, byte not kept
    end
  endfunction

  function automatic void filter_word(input logic [7:0] b, input logic eol);
    item_words.delete();
    if (ansi_on || !b[7]) begin
      close_seq();
      if (b >= SPACE_CHAR) item_words.push_back('{out_byte: b, end_of_run: 1'b0});
    end else if (b[7:6] == CONT_TAG && seq_cnt != 0) begin
      add_cont(b);
    end else begin
      close_seq();
      open_seq(b);
    end
    if (eol) close_seq();
    if (item_words.size() > 0) item_words[item_words.size()-1].end_of_run = 1'b1;
    foreach (item_words[i]) passed_words.push_back(item_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin
    out_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (passed_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got byte=%02h end_of_run=%0b",
                 $time, out_data.out_byte, out_data.end_of_run);
        errors++;
      end else begin
        due = passed_words.pop_front();
        if (out_data.out_byte !== due.out_byte) begin
          $display("%0t: out_byte mismatch, expected %02h, got %02h",
                   $time, due.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.end_of_run !== due.end_of_run) begin
          $display("%0t: end_of_run mismatch on byte %02h, expected %0b, got %0b",
                   $time, due.out_byte, due.end_of_run, out_data.end_of_run);
          errors++;
        end
      end
    end
  end

  // watchdog: ends the run after too many cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cyc <= 0;
    else
      stall_cyc <= stall_cyc + 1;
    if (stall_cyc >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // one word in; valid stays up after acceptance until the next negedge,
  // so every caller that waits on posedges lowers it first
  task automatic send_word(input logic [7:0] b, input logic eol);
    while (!calm && $urandom_range(0, 99) < 25) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_line: eol};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_word(b, eol);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // wait for all due words, then for work that makes no word, then write
  task automatic drain_output();
    hold_input();
    while (passed_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_ansi(input logic mode);
    drain_output();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ansi_on = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random scalar value of the given UTF-8 length, surrogates excluded
  function automatic logic [20:0] pick_cp(input int len);
    logic [20:0] cp;
    case (len)
      1:       cp = 21'($urandom_range('h20, 'h7f));
      2:       cp = 21'($urandom_range('h80, 'h7ff));
      3:       cp = 21'($urandom_range('h800, 'hffff));
      default: cp = 21'($urandom_range('h10000, 'h10ffff));
    endcase
    if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h800;
    return cp;
  endfunction

  // plain encoder: also used with out-of-rule values to build bad sequences
  function automatic logic [3:0][7:0] utf8_bytes(input logic [20:0] cp, input int len);
    logic [3:0][7:0] enc;
    enc = '0;
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {CONT_TAG, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {CONT_TAG, cp[11:6]};
        enc[2] = {CONT_TAG, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {CONT_TAG, cp[17:12]};
        enc[2] = {CONT_TAG, cp[11:6]};
        enc[3] = {CONT_TAG, cp[5:0]};
      end
    endcase
    return enc;
  endfunction

  // one chunk of random text: mostly well-formed characters, the rest
  // overlong, surrogate, out of range, cut short, overrun or raw bytes
  task automatic send_random_char(inout int sent);
    logic [3:0][7:0] enc;
    logic [20:0]     cp;
    int pick, len, keep, extra;
    pick  = $urandom_range(0, 99);
    len   = $urandom_range(1, 4);
    cp    = pick_cp(len);
    extra = 0;
    if (pick >= 65 && pick < 72) begin
      len = $urandom_range(2, 4);
      cp  = 21'($urandom_range(0, len == 2 ? 'h7f : len == 3 ? 'h7ff : 'hffff));
    end else if (pick >= 72 && pick < 77) begin
      len = 3;
      cp  = 21'($urandom_range('hd800, 'hdfff));
    end else if (pick >= 77 && pick < 81) begin
      len = 4;
      cp  = 21'($urandom_range('h110000, 'h1fffff));
    end else if (pick >= 81 && pick < 87) begin
      len = $urandom_range(2, 4);
      cp  = pick_cp(len);
    end else if (pick >= 87 && pick < 92) begin
      extra = $urandom_range(1, 4);
    end
    keep = (pick >= 81 && pick < 87) ? $urandom_range(1, len - 1) : len;
    enc  = utf8_bytes(cp, len);
    if (pick >= 92) begin
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      sent++;
    end else begin
      for (int i = 0; i < keep; i++) begin
        send_word(enc[i], $urandom_range(0, 9) == 0);
        sent++;
      end
      for (int i = 0; i < extra; i++) begin
        send_word({CONT_TAG, 6'($urandom_range(0, 63))}, $urandom_range(0, 9) == 0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // ASCII extremes and each kind of sequence verdict, UTF-8 mode
  task automatic test_directed_text();
    logic [8:0] words [25] = '{
      {8'h00, 1'b0}, {8'h1f, 1'b0}, {8'h20, 1'b0}, {8'h7f, 1'b1},   // ctrl, space, DEL
      {8'hc3, 1'b0}, {8'ha9, 1'b0}, {8'h41, 1'b0},                   // 2-byte, flushed by ASCII
      {8'hf0, 1'b0}, {8'h9f, 1'b0}, {8'h98, 1'b0}, {8'h80, 1'b0},   // 4-byte plus ASCII:
      {8'h41, 1'b1},                                                 //   five words on one item
      {8'hc0, 1'b0}, {8'h80, 1'b0},                                  // overlong
      {8'hed, 1'b0}, {8'ha0, 1'b0}, {8'h80, 1'b0},                   // surrogate
      {8'h80, 1'b0},                                                 // extra continuation on the surrogate run
      {8'hf0, 1'b0}, {8'h90, 1'b0}, {8'h80, 1'b0}, {8'h80, 1'b0},   // run past four bytes
      {8'h80, 1'b1},
      {8'hff, 1'b0},                                                 // lead with eight ones
      {8'hc3, 1'b1}                                                  // cut short by end of line
    };
    set_ansi(1'b0);
    foreach (words[i]) send_word(words[i][8:1], words[i][0]);
  endtask

  // sequence left pending in UTF-8 mode is judged by UTF-8 rules after the
  // switch to ANSI; then ANSI passes high bytes and drops controls
  task automatic test_mode_switch();
    send_word(8'hc3, 1'b0);
    send_word(8'ha9, 1'b0);
    set_ansi(1'b1);
    send_word(8'h41, 1'b0);
    send_word(8'h05, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h20, 1'b1);
  endtask

  task automatic test_random_text(input int n_words, input logic mode, input bit no_idle);
    int sent;
    set_ansi(mode);
    calm = no_idle;
    sent = 0;
    while (sent < n_words) send_random_char(sent);
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_text();
    test_mode_switch();
    test_random_text(150, 1'b0, 1'b0);
    test_random_text(80,  1'b1, 1'b0);
    test_random_text(100, 1'b0, 1'b1);  // back-to-back, no idling
    test_random_text(100, 1'b0, 1'b0);

    drain_output();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/u8f_pkg.sv
src/u8f_front.sv
src/u8f_queue.sv
src/u8f_back.sv
src/utf8_validating_byte_filter_top.sv
dv/testbench.sv
